// ----- design/drt_pkg.sv -----
// Shared types and constants for the damage rectangle transform core.
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;

	localparam int FIELD_W         = 28;
	localparam int COORD_FRAC_BITS = 8;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
	localparam int DEN_W           = FIELD_W - 1;
	localparam int PROD_W          = RATIO_W + 1 + FIELD_W;
	localparam int CW              = 36;
	localparam int PX_W            = 22;
	localparam int OUT_W           = 20;
	localparam int CFG_W           = 15;
	localparam int CFG_IDX_W       = 2;
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = 2;
	localparam int DCNT_W          = 5;

	localparam logic [CFG_W-1:0] DISP_W_RST        = 15'd1920;
	localparam logic [CFG_W-1:0] DISP_H_RST        = 15'd1080;
	localparam logic [OUT_W-1:0] EXT_MAX           = '1;
	localparam logic [RATIO_W-1:0] RATIO_ONE       = RATIO_W'(1) << RATIO_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_DISP_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_H = 2'd1;

	typedef enum logic [1:0] {
		REQ_CLEAR   = 2'd0,
		REQ_LOAD    = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_NOP     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		XF_NORMAL  = 3'd0,
		XF_R90     = 3'd1,
		XF_R180    = 3'd2,
		XF_R270    = 3'd3,
		XF_FLIP    = 3'd4,
		XF_FLIP90  = 3'd5,
		XF_FLIP180 = 3'd6,
		XF_FLIP270 = 3'd7
	} xform_t;

	// one queued beat: rect_a is x,y,w,h; dmg is x,y,w,h
	typedef struct packed {
		req_t                      req;
		xform_t                    xf;
		logic [3:0][FIELD_W-1:0]   rect_a;
		logic [3:0][FIELD_W-1:0]   dmg;
	} beat_t;

	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIVS,
		ST_DIVW,
		ST_MAP,
		ST_MUL,
		ST_ACC,
		ST_CLIP,
		ST_FIN
	} bk_state_t;

endpackage
`default_nettype wire

// ----- design/drt_front.sv -----
// Front end: accepts beats, drops unused request codes, queues the rest.
`timescale 1ns / 1ps
`default_nettype none
module drt_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  drt_pkg::beat_t    in_beat,
	output logic              q_valid,
	output drt_pkg::beat_t    q_head,
	input  wire logic         q_pop
);

	drt_pkg::beat_t mem_q [drt_pkg::QDEPTH];
	logic [drt_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [drt_pkg::QPTR_W:0]   count_q;
	logic push, accept, full;

	assign full     = (count_q == (drt_pkg::QPTR_W+1)'(drt_pkg::QDEPTH));
	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept && (in_beat.req != drt_pkg::REQ_NOP);
	assign q_valid  = (count_q != '0);
	assign q_head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/drt_div.sv -----
// Restoring divider: one quotient bit per cycle, ratio of num/den with num <= den.
`timescale 1ns / 1ps
`default_nettype none
module drt_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  drt_pkg::div_req_t  req,
	output drt_pkg::div_rsp_t  rsp
);

	logic [drt_pkg::DEN_W-1:0]   rem_q, den_q;
	logic [drt_pkg::RATIO_W-1:0] quo_q;
	logic [drt_pkg::DCNT_W-1:0]  cnt_q;
	logic                        busy_q, done_q;
	logic [drt_pkg::DEN_W:0]     rem2;
	logic                        bit_set;

	assign rem2    = {rem_q, 1'b0};
	assign bit_set = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= drt_pkg::DCNT_W'(drt_pkg::RATIO_FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == drt_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			if (req.num >= req.den) begin
				rem_q <= req.num - req.den;
				quo_q <= drt_pkg::RATIO_W'(1);
			end else begin
				rem_q <= req.num;
				quo_q <= '0;
			end
		end else if (busy_q) begin
			quo_q <= {quo_q[drt_pkg::RATIO_W-2:0], bit_set};
			if (bit_set) begin
				rem_q <= drt_pkg::DEN_W'(rem2 - {1'b0, den_q});
			end else begin
				rem_q <= rem2[drt_pkg::DEN_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

// ----- design/drt_back.sv -----
// Back end: holds latched rectangles, maps damage to pixels, merges the box.
`timescale 1ns / 1ps
`default_nettype none
module drt_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  drt_pkg::beat_t                   q_head,
	output logic                             q_pop,
	input  wire logic [drt_pkg::CFG_W-1:0]   out_w,
	input  wire logic [drt_pkg::CFG_W-1:0]   out_h,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             contributed,
	output logic                             box_valid,
	output logic signed [drt_pkg::OUT_W-1:0] box_left,
	output logic signed [drt_pkg::OUT_W-1:0] box_top,
	output logic [drt_pkg::OUT_W-1:0]        box_width,
	output logic [drt_pkg::OUT_W-1:0]        box_height
);

	localparam int FW = drt_pkg::FIELD_W;
	localparam int RW = drt_pkg::RATIO_W;
	localparam int CW = drt_pkg::CW;
	localparam int PW = drt_pkg::PX_W;
	localparam int OW = drt_pkg::OUT_W;

	drt_pkg::bk_state_t state_q, state_d;
	drt_pkg::div_req_t  dreq;
	drt_pkg::div_rsp_t  drsp;

	logic signed [FW-1:0] src_q [4];
	logic signed [FW-1:0] dmg_q [4];
	logic signed [FW-1:0] dst_q [4];
	drt_pkg::req_t        cur_req_q;
	drt_pkg::xform_t      xf_q;
	logic                 bad_q;
	logic [drt_pkg::DEN_W-1:0] num_q [4];
	logic [RW-1:0]        ratio_q [4];
	logic [RW-1:0]        lim_q [4];   // min_u, min_v, max_u, max_v
	logic [1:0]           d_q, m_q;
	logic signed [drt_pkg::PROD_W-1:0] prod_q;
	logic signed [CW-1:0] edge_q [4];  // x0, y0, x1, y1
	logic signed [PW-1:0] px_q [4];

	logic signed [OW-1:0] acc_l_q, acc_t_q;
	logic [OW-1:0]        acc_w_q, acc_h_q;
	logic                 acc_ne_q;
	logic                 out_valid_q;

	logic out_free, out_load;
	assign out_free = !out_valid_q || !out_stall;

	// ---- prep: damage/source intersection ----
	logic signed [FW:0]   sx1, sy1, ex1, ey1, ix0, iy0, ix1, iy1;
	logic signed [FW+1:0] n0, n1, n2, n3;
	logic                 prep_bad;

	always_comb begin
		sx1 = (FW+1)'(src_q[0]) + (FW+1)'(src_q[2]);
		sy1 = (FW+1)'(src_q[1]) + (FW+1)'(src_q[3]);
		ex1 = (FW+1)'(dmg_q[0]) + (FW+1)'(dmg_q[2]);
		ey1 = (FW+1)'(dmg_q[1]) + (FW+1)'(dmg_q[3]);
		ix0 = (src_q[0] > dmg_q[0]) ? (FW+1)'(src_q[0]) : (FW+1)'(dmg_q[0]);
		iy0 = (src_q[1] > dmg_q[1]) ? (FW+1)'(src_q[1]) : (FW+1)'(dmg_q[1]);
		ix1 = (sx1 < ex1) ? sx1 : ex1;
		iy1 = (sy1 < ey1) ? sy1 : ey1;
		n0  = (FW+2)'(ix0) - (FW+2)'(src_q[0]);
		n1  = (FW+2)'(ix1) - (FW+2)'(src_q[0]);
		n2  = (FW+2)'(iy0) - (FW+2)'(src_q[1]);
		n3  = (FW+2)'(iy1) - (FW+2)'(src_q[1]);
		prep_bad = (dmg_q[2] <= 0) || (dmg_q[3] <= 0) || (src_q[2] <= 0) ||
			(src_q[3] <= 0) || (ix1 <= ix0) || (iy1 <= iy0);
	end

	// ---- divider ----
	drt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// ---- corner transform and bounds ----
	function automatic logic [2*RW-1:0] map_corner(drt_pkg::xform_t t,
		logic [RW-1:0] u, logic [RW-1:0] v);
		logic [RW-1:0] nu, nv;
		nu = drt_pkg::RATIO_ONE - u;
		nv = drt_pkg::RATIO_ONE - v;
		unique case (t)
			drt_pkg::XF_R90:     map_corner = {nv, u};
			drt_pkg::XF_R180:    map_corner = {nu, nv};
			drt_pkg::XF_R270:    map_corner = {v, nu};
			drt_pkg::XF_FLIP:    map_corner = {nu, v};
			drt_pkg::XF_FLIP90:  map_corner = {v, u};
			drt_pkg::XF_FLIP180: map_corner = {u, nv};
			drt_pkg::XF_FLIP270: map_corner = {nv, nu};
			default:             map_corner = {u, v};
		endcase
	endfunction

	logic [RW-1:0] mn_u, mn_v, mx_u, mx_v;
	always_comb begin
		logic [2*RW-1:0] cm;
		mn_u = drt_pkg::RATIO_ONE;
		mn_v = drt_pkg::RATIO_ONE;
		mx_u = '0;
		mx_v = '0;
		for (int c = 0; c < 4; c++) begin
			cm = map_corner(xf_q, ratio_q[c & 1], ratio_q[2 + (c >> 1)]);
			if (cm[2*RW-1:RW] < mn_u) mn_u = cm[2*RW-1:RW];
			if (cm[RW-1:0] < mn_v)    mn_v = cm[RW-1:0];
			if (cm[2*RW-1:RW] > mx_u) mx_u = cm[2*RW-1:RW];
			if (cm[RW-1:0] > mx_v)    mx_v = cm[RW-1:0];
		end
	end

	// ---- scaling into the destination, one product per pass ----
	logic signed [drt_pkg::PROD_W-1:0] prod_d, shr;
	logic signed [FW-1:0] mul_b;
	logic signed [CW-1:0] dorg;
	always_comb begin
		mul_b  = m_q[0] ? dst_q[3] : dst_q[2];
		prod_d = $signed({1'b0, lim_q[m_q]}) * mul_b;
		if (m_q[1]) begin
			shr = (prod_q + drt_pkg::PROD_W'((1 << drt_pkg::RATIO_FRAC_BITS) - 1))
				>>> drt_pkg::RATIO_FRAC_BITS;
		end else begin
			shr = prod_q >>> drt_pkg::RATIO_FRAC_BITS;
		end
		dorg = CW'(m_q[0] ? dst_q[1] : dst_q[0]);
	end

	// ---- clip ----
	logic signed [CW-1:0] cx0, cy0, cx1, cy1, bx1, by1, x0, y0, x1, y1, cx1a, cy1a;
	logic signed [CW-1:0] fx0, fy0, fx1, fy1;
	always_comb begin
		cx0  = (dst_q[0] < 0) ? '0 : CW'(dst_q[0]);
		cy0  = (dst_q[1] < 0) ? '0 : CW'(dst_q[1]);
		cx1a = CW'(dst_q[0]) + CW'(dst_q[2]);
		cy1a = CW'(dst_q[1]) + CW'(dst_q[3]);
		bx1  = $signed(CW'({out_w, {drt_pkg::COORD_FRAC_BITS{1'b0}}}));
		by1  = $signed(CW'({out_h, {drt_pkg::COORD_FRAC_BITS{1'b0}}}));
		cx1  = (cx1a < bx1) ? cx1a : bx1;
		cy1  = (cy1a < by1) ? cy1a : by1;
		x0   = (edge_q[0] > cx0) ? edge_q[0] : cx0;
		y0   = (edge_q[1] > cy0) ? edge_q[1] : cy0;
		x1   = (edge_q[2] < cx1) ? edge_q[2] : cx1;
		y1   = (edge_q[3] < cy1) ? edge_q[3] : cy1;
		fx0  = x0 >>> drt_pkg::COORD_FRAC_BITS;
		fy0  = y0 >>> drt_pkg::COORD_FRAC_BITS;
		fx1  = (x1 + CW'((1 << drt_pkg::COORD_FRAC_BITS) - 1)) >>> drt_pkg::COORD_FRAC_BITS;
		fy1  = (y1 + CW'((1 << drt_pkg::COORD_FRAC_BITS) - 1)) >>> drt_pkg::COORD_FRAC_BITS;
	end

	// ---- merge ----
	logic                 contrib;
	logic signed [PW-1:0] ml, mt, mr, mb, ar, ab, ew, eh;
	logic signed [OW-1:0] nl, nt;
	logic [OW-1:0]        nw, nh;
	logic                 nne;
	always_comb begin
		contrib = (cur_req_q == drt_pkg::REQ_COMPUTE) && !bad_q;
		ar = PW'(acc_l_q) + $signed(PW'(acc_w_q));
		ab = PW'(acc_t_q) + $signed(PW'(acc_h_q));
		ml = px_q[0];
		mt = px_q[1];
		mr = px_q[2];
		mb = px_q[3];
		if (acc_ne_q) begin
			if (PW'(acc_l_q) < ml) ml = PW'(acc_l_q);
			if (PW'(acc_t_q) < mt) mt = PW'(acc_t_q);
			if (ar > mr) mr = ar;
			if (ab > mb) mb = ab;
		end
		ew = mr - ml;
		eh = mb - mt;
		if (cur_req_q == drt_pkg::REQ_CLEAR) begin
			nl = '0; nt = '0; nw = '0; nh = '0; nne = 1'b0;
		end else if (contrib) begin
			nl  = ml[OW-1:0];
			nt  = mt[OW-1:0];
			nw  = (ew > $signed(PW'(drt_pkg::EXT_MAX))) ? drt_pkg::EXT_MAX : ew[OW-1:0];
			nh  = (eh > $signed(PW'(drt_pkg::EXT_MAX))) ? drt_pkg::EXT_MAX : eh[OW-1:0];
			nne = 1'b1;
		end else begin
			nl = acc_l_q; nt = acc_t_q; nw = acc_w_q; nh = acc_h_q; nne = acc_ne_q;
		end
	end

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drt_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_head.req)
						drt_pkg::REQ_CLEAR:   state_d = drt_pkg::ST_FIN;
						drt_pkg::REQ_COMPUTE: state_d = drt_pkg::ST_PREP;
						default:              state_d = drt_pkg::ST_IDLE;
					endcase
				end
			end
			drt_pkg::ST_PREP: state_d = prep_bad ? drt_pkg::ST_FIN : drt_pkg::ST_DIVS;
			drt_pkg::ST_DIVS: state_d = drt_pkg::ST_DIVW;
			drt_pkg::ST_DIVW: begin
				if (drsp.done) begin
					state_d = (d_q == 2'd3) ? drt_pkg::ST_MAP : drt_pkg::ST_DIVS;
				end
			end
			drt_pkg::ST_MAP:  state_d = drt_pkg::ST_MUL;
			drt_pkg::ST_MUL:  state_d = drt_pkg::ST_ACC;
			drt_pkg::ST_ACC:  state_d = (m_q == 2'd3) ? drt_pkg::ST_CLIP : drt_pkg::ST_MUL;
			drt_pkg::ST_CLIP: state_d = drt_pkg::ST_FIN;
			drt_pkg::ST_FIN:  state_d = out_free ? drt_pkg::ST_IDLE : drt_pkg::ST_FIN;
			default:          state_d = drt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = (state_q == drt_pkg::ST_IDLE) && q_valid;
		dreq.start = (state_q == drt_pkg::ST_DIVS);
		dreq.num   = num_q[d_q];
		dreq.den   = d_q[1] ? src_q[3][drt_pkg::DEN_W-1:0] : src_q[2][drt_pkg::DEN_W-1:0];
		out_load   = (state_q == drt_pkg::ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			acc_ne_q    <= 1'b0;
			acc_l_q     <= '0;
			acc_t_q     <= '0;
			acc_w_q     <= '0;
			acc_h_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				src_q[i] <= '0;
				dmg_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (q_pop && q_head.req == drt_pkg::REQ_LOAD) begin
				for (int i = 0; i < 4; i++) begin
					src_q[i] <= $signed(q_head.rect_a[i]);
					dmg_q[i] <= $signed(q_head.dmg[i]);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				acc_l_q     <= nl;
				acc_t_q     <= nt;
				acc_w_q     <= nw;
				acc_h_q     <= nh;
				acc_ne_q    <= nne;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_req_q <= q_head.req;
			xf_q      <= q_head.xf;
			bad_q     <= 1'b0;
			d_q       <= '0;
			m_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				dst_q[i] <= $signed(q_head.rect_a[i]);
			end
		end
		if (state_q == drt_pkg::ST_PREP) begin
			bad_q    <= prep_bad;
			num_q[0] <= n0[drt_pkg::DEN_W-1:0];
			num_q[1] <= n1[drt_pkg::DEN_W-1:0];
			num_q[2] <= n2[drt_pkg::DEN_W-1:0];
			num_q[3] <= n3[drt_pkg::DEN_W-1:0];
		end
		if (state_q == drt_pkg::ST_DIVW && drsp.done) begin
			ratio_q[d_q] <= drsp.quo;
			d_q          <= d_q + 1'b1;
		end
		if (state_q == drt_pkg::ST_MAP) begin
			lim_q[0] <= mn_u;
			lim_q[1] <= mn_v;
			lim_q[2] <= mx_u;
			lim_q[3] <= mx_v;
		end
		if (state_q == drt_pkg::ST_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == drt_pkg::ST_ACC) begin
			edge_q[m_q] <= dorg + shr[CW-1:0];
			m_q         <= m_q + 1'b1;
		end
		if (state_q == drt_pkg::ST_CLIP) begin
			bad_q   <= (x1 <= x0) || (y1 <= y0);
			px_q[0] <= fx0[PW-1:0];
			px_q[1] <= fy0[PW-1:0];
			px_q[2] <= fx1[PW-1:0];
			px_q[3] <= fy1[PW-1:0];
		end
		if (out_load) begin
			contributed <= contrib;
			box_valid   <= nne;
			box_left    <= nne ? nl : '0;
			box_top     <= nne ? nt : '0;
			box_width   <= nne ? nw : '0;
			box_height  <= nne ? nh : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- design/damage_rect_transform_core.sv -----
// Top level of the damage rectangle transform core: config registers and channel wiring.
`timescale 1ns / 1ps
`default_nettype none
// Maps one layer's buffer damage into output pixels and grows a running
// scene damage box. A layer takes two input beats: a load beat (req_type 1)
// latches the source and damage rectangles, a compute beat (req_type 2)
// brings the destination rectangle and transform and yields one result beat.
// A clear beat (req_type 0) empties the box and yields one result beat;
// req_type 3 is dropped. Coordinates are signed Q19.8, ratios Q.16. Input
// beats land in a four-entry queue, so the input keeps taking beats while
// the back end works and while a result waits on out_stall, until the queue
// is full. In the back end a load beat is taken in the idle state and a
// clear beat passes through the finish state; a compute beat runs four serial
// ratio divisions (start, 16 quotient fraction bits, capture) in the shared
// divider, then four passes through the single scaling multiplier.
// The user must write the display width and height registers (index 0/1)
// only while the block idles; the block itself does not enforce it.
module damage_rect_transform_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          req_type,
	input  wire logic [2:0]                          transform,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_x,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_y,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_w,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_h,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_x,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_y,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_w,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_h,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     contributed,
	output logic                                     box_valid,
	output logic signed [drt_pkg::OUT_W-1:0]         box_left,
	output logic signed [drt_pkg::OUT_W-1:0]         box_top,
	output logic [drt_pkg::OUT_W-1:0]                box_width,
	output logic [drt_pkg::OUT_W-1:0]                box_height,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [drt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [drt_pkg::CFG_W-1:0]           cfg_data
);

	logic [drt_pkg::CFG_W-1:0] out_w_q, out_h_q;
	drt_pkg::beat_t in_beat, q_head;
	logic q_valid, q_pop;

	// config writes always land; unknown indexes are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_w_q <= drt_pkg::DISP_W_RST;
			out_h_q <= drt_pkg::DISP_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				drt_pkg::REG_DISP_W: out_w_q <= cfg_data;
				drt_pkg::REG_DISP_H: out_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pack one input beat
	always_comb begin
		in_beat.req       = drt_pkg::req_t'(req_type);
		in_beat.xf        = drt_pkg::xform_t'(transform);
		in_beat.rect_a[0] = rect_a_x;
		in_beat.rect_a[1] = rect_a_y;
		in_beat.rect_a[2] = rect_a_w;
		in_beat.rect_a[3] = rect_a_h;
		in_beat.dmg[0]    = damage_x;
		in_beat.dmg[1]    = damage_y;
		in_beat.dmg[2]    = damage_w;
		in_beat.dmg[3]    = damage_h;
	end

	drt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	drt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_w       (out_w_q),
		.out_h       (out_h_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.contributed (contributed),
		.box_valid   (box_valid),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_width   (box_width),
		.box_height  (box_height)
	);

endmodule
`default_nettype wire

// ----- tb/sv/damage_rect_transform_checker.sv -----
// Checker for the damage rectangle transform core: predicts the damage box and compares results.
`timescale 1ns / 1ps
module damage_rect_transform_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic [1:0]                          req_type,
	input  wire logic [2:0]                          transform,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_x,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_y,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_w,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  rect_a_h,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_x,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_y,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_w,
	input  wire logic signed [drt_pkg::FIELD_W-1:0]  damage_h,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic                                contributed,
	input  wire logic                                box_valid,
	input  wire logic [drt_pkg::OUT_W-1:0]           box_left,
	input  wire logic [drt_pkg::OUT_W-1:0]           box_top,
	input  wire logic [drt_pkg::OUT_W-1:0]           box_width,
	input  wire logic [drt_pkg::OUT_W-1:0]           box_height,
	input  wire logic                                cfg_valid,
	input  wire logic                                cfg_ready,
	input  wire logic [drt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [drt_pkg::CFG_W-1:0]           cfg_data,
	output int                                       fail_count,
	output int                                       boxes_pending,
	output int                                       boxes_seen,
	output int                                       layers_merged
);
	import drt_pkg::*;

	typedef struct packed {
		logic             contrib;
		logic             valid;
		logic [OUT_W-1:0] left;
		logic [OUT_W-1:0] top;
		logic [OUT_W-1:0] width;
		logic [OUT_W-1:0] height;
	} box_beat_t;

	localparam longint ONE_R   = longint'(1) << RATIO_FRAC_BITS;
	localparam longint EXT_SAT = 1048575;

	box_beat_t box_q[$];

	longint src_r[4], dmg_r[4];
	longint box_org[2], box_ext[2];
	bit     box_on;
	longint out_w, out_h;

	function automatic longint fl_sh(longint p, int s);
		return p >>> s;
	endfunction

	function automatic longint cl_sh(longint p, int s);
		return -((-p) >>> s);
	endfunction

	function automatic longint mn(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint mx(longint a, longint b);
		return a > b ? a : b;
	endfunction

	// maps a layer into pixel edges; returns 0 when nothing lands
	function automatic bit layer_pixels(xform_t xf, longint dst[4], output longint px[4]);
		longint ix0, iy0, ix1, iy1, u, v, lo_u, lo_v, hi_u, hi_v;
		longint ru[2], rv[2];
		longint x0, y0, x1, y1;
		px = '{0, 0, 0, 0};
		if (dmg_r[2] <= 0 || dmg_r[3] <= 0 || src_r[2] <= 0 || src_r[3] <= 0)
			return 0;
		ix0 = mx(src_r[0], dmg_r[0]);
		iy0 = mx(src_r[1], dmg_r[1]);
		ix1 = mn(src_r[0] + src_r[2], dmg_r[0] + dmg_r[2]);
		iy1 = mn(src_r[1] + src_r[3], dmg_r[1] + dmg_r[3]);
		if (ix1 <= ix0 || iy1 <= iy0)
			return 0;
		ru[0] = ((ix0 - src_r[0]) << RATIO_FRAC_BITS) / src_r[2];
		ru[1] = ((ix1 - src_r[0]) << RATIO_FRAC_BITS) / src_r[2];
		rv[0] = ((iy0 - src_r[1]) << RATIO_FRAC_BITS) / src_r[3];
		rv[1] = ((iy1 - src_r[1]) << RATIO_FRAC_BITS) / src_r[3];
		lo_u = ONE_R; lo_v = ONE_R; hi_u = 0; hi_v = 0;
		for (int c = 0; c < 4; c++) begin
			case (xf)
				XF_R90:     begin u = ONE_R - rv[c>>1]; v = ru[c&1]; end
				XF_R180:    begin u = ONE_R - ru[c&1]; v = ONE_R - rv[c>>1]; end
				XF_R270:    begin u = rv[c>>1]; v = ONE_R - ru[c&1]; end
				XF_FLIP:    begin u = ONE_R - ru[c&1]; v = rv[c>>1]; end
				XF_FLIP90:  begin u = rv[c>>1]; v = ru[c&1]; end
				XF_FLIP180: begin u = ru[c&1]; v = ONE_R - rv[c>>1]; end
				XF_FLIP270: begin u = ONE_R - rv[c>>1]; v = ONE_R - ru[c&1]; end
				default:    begin u = ru[c&1]; v = rv[c>>1]; end
			endcase
			lo_u = mn(lo_u, u); lo_v = mn(lo_v, v);
			hi_u = mx(hi_u, u); hi_v = mx(hi_v, v);
		end
		x0 = mx(mx(dst[0], 0), dst[0] + fl_sh(lo_u * dst[2], RATIO_FRAC_BITS));
		y0 = mx(mx(dst[1], 0), dst[1] + fl_sh(lo_v * dst[3], RATIO_FRAC_BITS));
		x1 = mn(mn(dst[0] + dst[2], out_w << COORD_FRAC_BITS),
			dst[0] + cl_sh(hi_u * dst[2], RATIO_FRAC_BITS));
		y1 = mn(mn(dst[1] + dst[3], out_h << COORD_FRAC_BITS),
			dst[1] + cl_sh(hi_v * dst[3], RATIO_FRAC_BITS));
		if (x1 <= x0 || y1 <= y0)
			return 0;
		px[0] = fl_sh(x0, COORD_FRAC_BITS);
		px[1] = fl_sh(y0, COORD_FRAC_BITS);
		px[2] = cl_sh(x1, COORD_FRAC_BITS);
		px[3] = cl_sh(y1, COORD_FRAC_BITS);
		return 1;
	endfunction

	// applies one accepted input beat; pushes the box beat it yields, if any
	task automatic predict_box(logic [1:0] rq, logic [2:0] xf, longint a[4], longint d[4]);
		longint px[4];
		longint l, t, r, b;
		box_beat_t e;
		e = '0;
		case (req_t'(rq))
			REQ_LOAD: begin
				src_r = a;
				dmg_r = d;
				return;
			end
			REQ_NOP: return;
			REQ_CLEAR: begin
				box_org = '{0, 0};
				box_ext = '{0, 0};
				box_on = 0;
			end
			default: begin
				if (layer_pixels(xform_t'(xf), a, px)) begin
					l = px[0]; t = px[1]; r = px[2]; b = px[3];
					if (box_on) begin
						l = mn(l, box_org[0]);
						t = mn(t, box_org[1]);
						r = mx(r, box_org[0] + box_ext[0]);
						b = mx(b, box_org[1] + box_ext[1]);
					end
					box_org = '{l, t};
					box_ext = '{mn(r - l, EXT_SAT), mn(b - t, EXT_SAT)};
					box_on = 1;
					e.contrib = 1;
				end
			end
		endcase
		e.valid = box_on;
		if (box_on) begin
			e.left   = box_org[0][OUT_W-1:0];
			e.top    = box_org[1][OUT_W-1:0];
			e.width  = box_ext[0][OUT_W-1:0];
			e.height = box_ext[1][OUT_W-1:0];
		end
		box_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint a[4], d[4];
		box_beat_t got, want;
		if (!arst_n) begin
			src_r = '{0, 0, 0, 0};
			dmg_r = '{0, 0, 0, 0};
			box_org = '{0, 0};
			box_ext = '{0, 0};
			box_on = 0;
			out_w = DISP_W_RST;
			out_h = DISP_H_RST;
			box_q.delete();
			fail_count = 0;
			boxes_seen = 0;
			layers_merged = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DISP_W)
					out_w = cfg_data;
				else if (cfg_index == REG_DISP_H)
					out_h = cfg_data;
			end
			if (out_valid && !out_stall) begin
				got = {contributed, box_valid, box_left, box_top, box_width, box_height};
				boxes_seen++;
				if (contributed)
					layers_merged++;
				if (box_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: box beat with nothing expected: %p", $realtime, got);
				end else begin
					want = box_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: box mismatch exp %p got %p", $realtime, want, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				a = '{longint'(rect_a_x), longint'(rect_a_y),
					longint'(rect_a_w), longint'(rect_a_h)};
				d = '{longint'(damage_x), longint'(damage_y),
					longint'(damage_w), longint'(damage_h)};
				predict_box(req_type, transform, a, d);
			end
		end
		boxes_pending = box_q.size();
	end

endmodule

// ----- tb/sv/damage_rect_transform_core_tb.sv -----
// Testbench top for the damage rectangle transform core: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module damage_rect_transform_core_tb;
	import drt_pkg::*;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 req_type;
	logic [2:0]                 transform;
	logic signed [FIELD_W-1:0]  rect_a_x, rect_a_y, rect_a_w, rect_a_h;
	logic signed [FIELD_W-1:0]  damage_x, damage_y, damage_w, damage_h;
	logic                       out_valid;
	logic                       out_stall;
	logic                       contributed, box_valid;
	logic signed [OUT_W-1:0]    box_left, box_top;
	logic [OUT_W-1:0]           box_width, box_height;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	int fail_count, boxes_pending, boxes_seen, layers_merged;
	int beats_sent;

	// receiver side: per-beat random stall plus one long hold-off
	logic rx_stall;
	logic long_hold;
	logic hold_go;
	logic quiet;   // no idling on either side
	int   rx_wait;

	assign out_stall = rx_stall | long_hold;

	// one input beat: rect is x,y,w,h of source or destination; dmg is damage
	typedef struct packed {
		req_t                    rq;
		logic [2:0]              xf;
		logic [3:0][FIELD_W-1:0] rect;
		logic [3:0][FIELD_W-1:0] dmg;
	} layer_beat_t;

	localparam logic [FIELD_W-1:0] F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic [FIELD_W-1:0] F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	damage_rect_transform_core uut (.*);

	damage_rect_transform_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#15_000_000;
		$display("timeout with %0d box beats outstanding", boxes_pending);
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			rx_stall <= 1'b0;
			rx_wait  <= 0;
		end else if (rx_wait > 0) begin
			rx_wait  <= rx_wait - 1;
			rx_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			// beat taken now: draw the wait before the next one
			w = quiet ? 0 : $urandom_range(0, 15);
			rx_stall <= (w > 0);
			rx_wait  <= (w > 0) ? w - 1 : 0;
		end else begin
			rx_stall <= 1'b0;
		end
	end

	// long hold-off, counted here so the sender keeps offering beats meanwhile
	initial begin
		long_hold <= 1'b0;
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (700) @(posedge clk);
		long_hold <= 1'b0;
	end

	function automatic logic [FIELD_W-1:0] rnd_any();
		return FIELD_W'($urandom);
	endfunction

	// small coordinate, mostly on screen
	function automatic logic [FIELD_W-1:0] rnd_pos();
		return FIELD_W'(int'($urandom_range(0, 700000)) - 60000);
	endfunction

	function automatic logic [FIELD_W-1:0] rnd_len();
		return FIELD_W'($urandom_range(1, 300000));
	endfunction

	task automatic send(layer_beat_t b);
		int  gap;
		bit  ok;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type  <= b.rq;
		transform <= b.xf;
		{rect_a_h, rect_a_w, rect_a_y, rect_a_x} <= b.rect;
		{damage_h, damage_w, damage_y, damage_x} <= b.dmg;
		in_valid  <= 1'b1;
		// stall is settled by the falling edge; the beat goes at the next rise
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		if (b.rq != REQ_NOP)
			beats_sent++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		bit ok;
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
	endtask

	// all results back, then room for a trailing load beat in the back end
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (boxes_pending == 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic layer_beat_t mk(req_t rq, logic [2:0] xf,
			logic [FIELD_W-1:0] ax, ay, aw, ah, dx, dy, dw, dh);
		layer_beat_t b;
		b.rq = rq;
		b.xf = xf;
		b.rect = {ah, aw, ay, ax};
		b.dmg = {dh, dw, dy, dx};
		return b;
	endfunction

	// well-formed layer: damage mostly overlaps the source
	task automatic good_layer();
		logic [FIELD_W-1:0] sx, sy, sw, sh;
		sx = rnd_pos(); sy = rnd_pos(); sw = rnd_len(); sh = rnd_len();
		send(mk(REQ_LOAD, 3'($urandom), sx, sy, sw, sh,
			sx + FIELD_W'($urandom_range(0, 200000)) - FIELD_W'(50000),
			sy + FIELD_W'($urandom_range(0, 200000)) - FIELD_W'(50000),
			rnd_len(), rnd_len()));
		send(mk(REQ_COMPUTE, 3'($urandom), rnd_pos(), rnd_pos(), rnd_len(), rnd_len(),
			rnd_any(), rnd_any(), rnd_any(), rnd_any()));
		if ($urandom_range(0, 4) == 0)
			send(mk(REQ_COMPUTE, 3'($urandom), rnd_pos(), rnd_pos(), rnd_len(), rnd_len(),
				rnd_any(), rnd_any(), rnd_any(), rnd_any()));
	endtask

	task automatic random_run(int count, int pause_at);
		int      start, r;
		bit      paused;
		start = beats_sent;
		paused = 0;
		while (beats_sent - start < count) begin
			if (pause_at > 0 && !paused && beats_sent - start >= pause_at) begin
				// sender waits until every result is home
				in_valid <= 1'b0;
				@(posedge clk);
				wait (boxes_pending == 0);
				@(posedge clk);
				paused = 1;
			end
			r = $urandom_range(0, 99);
			if (r < 72)
				good_layer();
			else if (r < 80)
				send(mk(REQ_CLEAR, 3'($urandom), rnd_any(), rnd_any(), rnd_any(),
					rnd_any(), rnd_any(), rnd_any(), rnd_any(), rnd_any()));
			else if (r < 84)
				send(mk(REQ_NOP, 3'($urandom), rnd_any(), rnd_any(), rnd_any(),
					rnd_any(), rnd_any(), rnd_any(), rnd_any(), rnd_any()));
			else
				// noise: any request with raw field values
				send(mk(req_t'(2'($urandom)), 3'($urandom), rnd_any(), rnd_any(),
					rnd_any(), rnd_any(), rnd_any(), rnd_any(), rnd_any(), rnd_any()));
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= REQ_CLEAR;
		transform <= XF_NORMAL;
		{rect_a_x, rect_a_y, rect_a_w, rect_a_h} <= '0;
		{damage_x, damage_y, damage_w, damage_h} <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DISP_W;
		cfg_data  <= '0;
		hold_go   <= 1'b0;
		quiet     <= 1'b0;
		beats_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: compute before any load, then clear
		send(mk(REQ_COMPUTE, XF_NORMAL, 0, 0, 28'd25600, 28'd25600, 0, 0, 0, 0));
		send(mk(REQ_CLEAR, XF_NORMAL, 0, 0, 0, 0, 0, 0, 0, 0));
		// one layer through every transform, source and damage reused
		send(mk(REQ_LOAD, XF_NORMAL, 28'd2560, 28'd5120, 28'd25600, 28'd12800,
			28'd5120, 28'd6400, 28'd7680, 28'd2560));
		for (int t = 0; t < 8; t++)
			send(mk(REQ_COMPUTE, 3'(t), 28'd12800 * FIELD_W'(t), 28'd3840,
				28'd51200, 28'd38400, 0, 0, 0, 0));
		// ignored request type, then a negative destination size
		send(mk(REQ_NOP, XF_FLIP, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN));
		send(mk(REQ_COMPUTE, XF_R90, 28'd256, 28'd256, F_MIN, 28'd2560, 0, 0, 0, 0));
		// empty damage, disjoint damage, empty source
		send(mk(REQ_LOAD, XF_NORMAL, 0, 0, 28'd25600, 28'd25600, 0, 0, 0, 28'd256));
		send(mk(REQ_COMPUTE, XF_NORMAL, 0, 0, 28'd25600, 28'd25600, 0, 0, 0, 0));
		send(mk(REQ_LOAD, XF_NORMAL, 0, 0, 28'd2560, 28'd2560, 28'd5120, 0, 28'd256,
			28'd256));
		send(mk(REQ_COMPUTE, XF_FLIP90, 0, 0, 28'd25600, 28'd25600, 0, 0, 0, 0));
		send(mk(REQ_LOAD, XF_NORMAL, 0, 0, F_MIN, 28'd2560, 0, 0, 28'd256, 28'd256));
		send(mk(REQ_COMPUTE, XF_FLIP180, 0, 0, 28'd25600, 28'd25600, 0, 0, 0, 0));
		// field extremes: huge source and damage, destination past the output area
		send(mk(REQ_LOAD, XF_NORMAL, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN, F_MIN, F_MAX, F_MAX));
		send(mk(REQ_COMPUTE, XF_FLIP270, F_MIN, F_MIN, F_MAX, F_MAX, 0, 0, 0, 0));
		send(mk(REQ_COMPUTE, XF_R270, F_MAX, F_MAX, F_MAX, F_MAX, 0, 0, 0, 0));
		send(mk(REQ_CLEAR, XF_NORMAL, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// phases over output sizes, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin cfg_write(REG_DISP_W, 15'd1); cfg_write(REG_DISP_H, 15'd1); end
				1: begin cfg_write(REG_DISP_W, 15'd16384);
					cfg_write(REG_DISP_H, 15'd16384); end
				2: begin cfg_write(REG_DISP_W, 15'd1920);
					cfg_write(REG_DISP_H, 15'd1080); end
				default: begin
					cfg_write(REG_DISP_W, 15'($urandom_range(1, 16384)));
					cfg_write(REG_DISP_H, 15'($urandom_range(1, 16384)));
				end
			endcase
			quiet <= (ph == 3);
			if (ph == 2)
				hold_go <= 1'b1;
			random_run(ph == 0 ? 140 : 190, ph == 4 ? 90 : 0);
			drain();
		end

		$display("%0d beats sent, %0d box beats checked, %0d layers merged",
			beats_sent, boxes_seen, layers_merged);
		$display("covered all transforms, empty and clipped layers, output sizes 1 to 16384");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- damage_rect_transform_core.f -----
design/drt_pkg.sv
design/drt_front.sv
design/drt_div.sv
design/drt_back.sv
design/damage_rect_transform_core.sv
tb/sv/damage_rect_transform_checker.sv
tb/sv/damage_rect_transform_core_tb.sv
